// ===== design/kerning_pair_hash_table_assert.svh =====
`ifndef KERNING_PAIR_HASH_TABLE_ASSERT_SVH
`define KERNING_PAIR_HASH_TABLE_ASSERT_SVH

// same-cycle implication
`define KPHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication
`define KPHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== design/khash_pkg.sv =====
package khash_pkg;

  localparam int TABLE_DEPTH = 16 * 1024;
  localparam int MAX_PROBES  = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int PROBE_W     = $clog2(MAX_PROBES + 1);
  localparam int CODE_W      = 16;
  localparam int KERN_W      = 8;
  localparam int HASH_W      = CODE_W + 6;

  typedef struct packed {
    logic [CODE_W-1:0] left_code;
    logic [CODE_W-1:0] right_code;
    logic [KERN_W-1:0] amount;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_CHECK
  } state_t;

  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_MISS  = 2'd1,
    ST_LIMIT = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // home slot: left*19 + right*7 by shift-add, masked to the table size
  function automatic logic [IDX_W-1:0] hash_home(input logic [CODE_W-1:0] left_code,
                                                 input logic [CODE_W-1:0] right_code);
    logic [HASH_W-1:0] l;
    logic [HASH_W-1:0] r;
    logic [HASH_W-1:0] h;
    l = HASH_W'(left_code);
    r = HASH_W'(right_code);
    h = (l << 4) + (l << 1) + l + (r << 3) - r;
    return h[IDX_W-1:0];
  endfunction

endpackage

// ===== design/khash_mem.sv =====
module khash_mem
  import khash_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = entry_t'(rdata_r);

endmodule

// ===== design/kerning_pair_hash_table.sv =====
// a zero key, or a lookup with kerning off, is answered in the cycle after start without
// probing; other requests probe until a hit, an empty slot or the probe limit, each probe
// a read then a compare on the table memory with registered read data; no new request is
// taken while busy; reset: synchronous, clears the enable register, then clears all 16384
// slots with busy high; the receiver cannot stall, each result beat lasts one cycle
module kerning_pair_hash_table
  import khash_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_operation,
  input  logic [CODE_W-1:0]        in_left_code,
  input  logic [CODE_W-1:0]        in_right_code,
  input  logic signed [KERN_W-1:0] in_kern_in,
  output logic                     out_valid,
  output logic signed [KERN_W-1:0] out_kern_out,
  output logic [1:0]               out_status,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata
);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic               en_r;
  logic               op_r, op_nxt;
  logic [CODE_W-1:0]  left_r, left_nxt;
  logic [CODE_W-1:0]  right_r, right_nxt;
  logic [KERN_W-1:0]  kern_r, kern_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   sq_r, sq_nxt;
  logic [PROBE_W-1:0] step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [KERN_W-1:0]  out_kern_r, out_kern_nxt;
  status_t            out_status_r, out_status_nxt;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  entry_t             mem_rdata;
  logic               slot_empty;
  logic               slot_match;

  khash_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx_r),
    .rdata (mem_rdata)
  );

  assign slot_empty = (mem_rdata.left_code == '0);
  assign slot_match = (mem_rdata.left_code == left_r) && (mem_rdata.right_code == right_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      en_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        en_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    left_r       <= left_nxt;
    right_r      <= right_nxt;
    kern_r       <= kern_nxt;
    idx_r        <= idx_nxt;
    sq_r         <= sq_nxt;
    step_r       <= step_nxt;
    out_kern_r   <= out_kern_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    op_nxt         = op_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    kern_nxt       = kern_r;
    idx_nxt        = idx_r;
    sq_nxt         = sq_r;
    step_nxt       = step_r;
    out_valid_nxt  = 1'b0;
    out_kern_nxt   = out_kern_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = '{left_code: left_r, right_code: right_r, amount: kern_r};

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_W'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_operation;
          left_nxt  = in_left_code;
          right_nxt = in_right_code;
          kern_nxt  = in_kern_in;
          idx_nxt   = hash_home(in_left_code, in_right_code);
          sq_nxt    = IDX_W'(1);
          step_nxt  = PROBE_W'(1);
          if (in_left_code == '0) begin
            out_valid_nxt  = 1'b1;
            out_kern_nxt   = '0;
            out_status_nxt = ST_ZERO;
          end else if (in_operation == OP_LOOKUP && !en_r) begin
            out_valid_nxt  = 1'b1;
            out_kern_nxt   = '0;
            out_status_nxt = ST_MISS;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (slot_empty || slot_match) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          out_kern_nxt  = '0;
          if (op_r == OP_INSERT) begin
            mem_we         = 1'b1;
            out_status_nxt = ST_HIT;
          end else if (slot_match) begin
            out_kern_nxt   = mem_rdata.amount;
            out_status_nxt = ST_HIT;
          end else begin
            out_status_nxt = ST_MISS;
          end
        end else if (step_r == PROBE_W'(MAX_PROBES)) begin
          out_valid_nxt  = 1'b1;
          out_kern_nxt   = '0;
          out_status_nxt = ST_LIMIT;
          state_nxt      = S_IDLE;
        end else begin
          // next offset square: (k+1)^2 = k^2 + 2k + 1
          idx_nxt   = idx_r + sq_r;
          sq_nxt    = sq_r + IDX_W'({step_r, 1'b1});
          step_nxt  = step_r + 1'b1;
          state_nxt = S_PROBE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_kern_out = out_kern_r;
  assign out_status   = out_status_r;

`include "kerning_pair_hash_table_assert.svh"

  `KPHT_ASSERT_NOW(a_out_has_cause, out_valid, $past(start || busy))
  `KPHT_ASSERT_NOW(a_we_states, mem_we, (state_r == S_CLEAR || state_r == S_CHECK))
  `KPHT_ASSERT_NOW(a_no_zero_key_store, (mem_we && state_r == S_CHECK), (left_r != '0))
  `KPHT_ASSERT_NEXT(a_accept_progress, (start && !busy), (busy || out_valid))

endmodule
